// ===== hdl/sacf_pkg.sv =====
// Shared types and constants of the sample autocorrelation block.
package sacf_pkg;

   // Accumulator and ratio widths
   localparam int ACC_W = 64;
   localparam int Q_W = 17;
   localparam int DIV_STEPS = 16;
   localparam int DRAIN_CYC = 5;

   localparam logic [15:0] ONE_Q14 = 16'd16384;

   // Error codes on the result word
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_LAG = 2'd1;
   localparam logic [1:0] ERR_OVF = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_STREAM,
      ST_DRAIN,
      ST_DEN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_FAULT
   } state_type;

   // Control of the lag cells
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== hdl/sacf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sacf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/sacf_cell.sv =====
// One lag cell: delay tap, product register and lag accumulator.
module sacf_cell #(
   parameter int DW = 28
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sacf_pkg::cell_ctl_type      ctl,
   input  logic signed [DW-1:0]        head_d,
   input  logic                        head_v,
   input  logic signed [DW-1:0]        tap_d_i,
   input  logic                        tap_v_i,
   output logic signed [DW-1:0]        tap_d_o,
   output logic                        tap_v_o,
   input  logic [sacf_pkg::ACC_W-1:0]  acc_i,
   output logic [sacf_pkg::ACC_W-1:0]  acc_o
);
   import sacf_pkg::*;

   logic signed [2*DW-1:0] prod_ff;
   logic                   prod_v_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic [ACC_W-1:0]       prod_ext;

   assign prod_ext = ACC_W'(prod_ff);

   // tap delay and multiply
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         tap_v_o   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         tap_v_o   <= tap_v_i;
         prod_v_ff <= head_v & tap_v_i;
      end
      tap_d_o <= tap_d_i;
      prod_ff <= head_d * tap_d_i;
   end

   // accumulate, or hand down towards lag 0
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.shift) begin
         acc_ff <= acc_i;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + prod_ext;
      end
   end

   assign acc_o = acc_ff;
endmodule

// ===== hdl/sacf_div.sv =====
// Iterative restoring divider giving a rounded Q2.14 ratio.
module sacf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sacf_pkg::ACC_W-1:0] num,
   input  logic [sacf_pkg::ACC_W-1:0] den,
   output logic                       done,
   output logic [15:0]                value
);
   import sacf_pkg::*;

   logic                      run_ff;
   logic [4:0]                cnt_ff;
   logic [ACC_W-1:0]          rem_ff;
   logic [ACC_W-1:0]          den_ff;
   logic [Q_W-1:0]            q_ff;
   logic                      neg_ff;
   logic [ACC_W-1:0]          rem_sh;
   logic [Q_W-1:0]            q_sh;
   logic                      take;
   logic [ACC_W-1:0]          rem_in;
   logic [Q_W-1:0]            q_in;
   logic [Q_W:0]              rnd;
   logic [15:0]               mag16;

   // first step compares unshifted, later steps shift one bit in
   always_comb begin
      rem_sh = (cnt_ff == 5'd0) ? rem_ff : {rem_ff[ACC_W-2:0], 1'b0};
      q_sh   = (cnt_ff == 5'd0) ? q_ff : {q_ff[Q_W-2:0], 1'b0};
      take   = rem_sh >= den_ff;
      rem_in = take ? rem_sh - den_ff : rem_sh;
      q_in   = q_sh | Q_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 5'(DIV_STEPS - 1)) begin
            run_ff <= 1'b0;
            done   <= 1'b1;
         end
      end
      if (start) begin
         neg_ff <= num[ACC_W-1];
         rem_ff <= num[ACC_W-1] ? ACC_W'(0) - num : num;
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   // round half up on the magnitude, clamp to one, restore sign
   always_comb begin
      rnd   = ({1'b0, q_ff} + (Q_W+1)'(1)) >> 1;
      mag16 = (rnd > (Q_W+1)'(ONE_Q14)) ? ONE_Q14 : rnd[15:0];
      value = neg_ff ? 16'd0 - mag16 : mag16;
   end
endmodule

// ===== hdl/sample_autocorrelation.sv =====
// Top level of the sample autocorrelation block.
// Samples are taken one per cycle while busy is low; the word marked last
// starts the run. The deviations n*x-S are then streamed from the sample RAM
// through a row of MAX_LAGS+1 lag cells, one multiply-accumulate per cell
// per cycle. Streaming and draining come before the lag 0 word, then each
// further lag takes its turn in the shared divider (skipped, giving zero,
// when the series is constant). Lag 0 (always 1.0) comes out as soon as
// the sums are ready. Each result is shown for a
// single cycle under rsp_valid; the receiver cannot stall, so it must take
// every word. Errors give one word only. Configure max_lag only while idle.
module sample_autocorrelation #(
   parameter int DEPTH = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_LAGS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_sample,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic [5:0]         rsp_lag,
   output logic signed [15:0] rsp_acf_value,
   output logic [1:0]         rsp_error,
   output logic               rsp_end_of_run,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data
);
   import sacf_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int SUMW = SAMPLE_BITS + CW;
   localparam int DW = SAMPLE_BITS + CW + 1;
   localparam int NCELL = MAX_LAGS + 1;

   state_type state_ff, state_in;

   logic [5:0]                   max_lag_ff;
   logic [5:0]                   ml;
   logic [CW-1:0]                count_ff;
   logic signed [SUMW-1:0]       sum_ff;
   logic                         ovf_ff;
   logic                         accept;
   logic                         room;
   logic [CW-1:0]                n_new;
   logic                         ovf_new;
   logic signed [SAMPLE_BITS-1:0] x_in;
   logic                         series_clr;

   logic [CW-1:0]                rd_idx_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic                         v1_ff, v2_ff, head_v_ff;
   logic signed [DW-1:0]         nx_ff, head_d_ff;
   logic [2:0]                   drain_ff;

   cell_ctl_type                 ctl;
   logic signed [DW-1:0]         tap_d [NCELL];
   logic                         tap_v [NCELL];
   logic [ACC_W-1:0]             acc_w [NCELL+1];

   logic [ACC_W-1:0]             den_ff;
   logic [5:0]                   lag_ff;
   logic [1:0]                   err_ff;
   logic                         div_start;
   logic                         div_done;
   logic [15:0]                  div_value;
   logic [15:0]                  val_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_lag_ff <= 6'd10;
      end else if (csr_wr_en) begin
         max_lag_ff <= csr_wr_data;
      end
   end
   assign ml = (max_lag_ff > 6'(MAX_LAGS)) ? 6'(MAX_LAGS) : max_lag_ff;

   // loading
   assign busy    = (state_ff != ST_LOAD);
   assign accept  = start && !busy;
   assign room    = count_ff < CW'(DEPTH);
   assign x_in    = SAMPLE_BITS'(req_sample);
   assign n_new   = room ? count_ff + CW'(1) : count_ff;
   assign ovf_new = ovf_ff || !room;

   always_ff @(posedge clock) begin
      if (reset || series_clr) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (room) begin
            count_ff <= count_ff + CW'(1);
            sum_ff   <= sum_ff + SUMW'(x_in);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   sacf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (accept && room),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (x_in),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // deviation pipeline: read, n*x, minus sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         head_v_ff <= 1'b0;
      end else begin
         v1_ff     <= (state_ff == ST_STREAM);
         v2_ff     <= v1_ff;
         head_v_ff <= v2_ff;
      end
      nx_ff     <= $signed({1'b0, count_ff}) * rd_data;
      head_d_ff <= nx_ff - DW'(sum_ff);
   end

   // read index and drain counter
   always_ff @(posedge clock) begin
      if (state_ff == ST_STREAM) begin
         rd_idx_ff <= rd_idx_ff + CW'(1);
      end else begin
         rd_idx_ff <= '0;
      end
      if (state_ff == ST_DRAIN) begin
         drain_ff <= drain_ff + 3'd1;
      end else begin
         drain_ff <= '0;
      end
   end

   // row of lag cells
   assign acc_w[NCELL] = '0;
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      if (k == 0) begin : g_first
         sacf_cell #(.DW(DW)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .head_d(head_d_ff), .head_v(head_v_ff),
            .tap_d_i(head_d_ff), .tap_v_i(head_v_ff),
            .tap_d_o(tap_d[k]), .tap_v_o(tap_v[k]),
            .acc_i(acc_w[k+1]), .acc_o(acc_w[k])
         );
      end else begin : g_rest
         sacf_cell #(.DW(DW)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .head_d(head_d_ff), .head_v(head_v_ff),
            .tap_d_i(tap_d[k-1]), .tap_v_i(tap_v[k-1]),
            .tap_d_o(tap_d[k]), .tap_v_o(tap_v[k]),
            .acc_i(acc_w[k+1]), .acc_o(acc_w[k])
         );
      end
   end

   sacf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_w[0]),
      .den   (den_ff),
      .done  (div_done),
      .value (div_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) begin
               if (ovf_new || {{CW{1'b0}}, ml} >= {6'd0, n_new}) begin
                  state_in = ST_FAULT;
               end else begin
                  state_in = ST_STREAM;
               end
            end
         end
         ST_STREAM: begin
            if (rd_idx_ff == count_ff - CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 3'(DRAIN_CYC - 1)) begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            state_in = (ml == 6'd0) ? ST_LOAD : ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = (den_ff == '0) ? ST_EMIT : ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = (lag_ff == ml) ? ST_LOAD : ST_DIV_GO;
         end
         ST_FAULT: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control outputs
   always_comb begin
      ctl.clear  = (state_ff == ST_LOAD);
      ctl.shift  = (state_ff == ST_DEN) || (state_ff == ST_EMIT);
      div_start  = (state_ff == ST_DIV_GO) && (den_ff != '0);
      series_clr = (state_ff != ST_LOAD) && (state_in == ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // run bookkeeping
   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         err_ff <= ovf_new ? ERR_OVF : ERR_LAG;
      end
      if (state_ff == ST_DEN) begin
         den_ff <= acc_w[0];
         lag_ff <= 6'd1;
      end else if (state_ff == ST_EMIT) begin
         lag_ff <= lag_ff + 6'd1;
      end
      if (state_ff == ST_DIV_GO) begin
         val_ff <= '0;
      end else if (div_done) begin
         val_ff <= div_value;
      end
   end

   // result word, one cycle per word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_DEN) || (state_ff == ST_EMIT) ||
                      (state_ff == ST_FAULT);
      end
      case (state_ff)
         ST_DEN: begin
            rsp_lag        <= 6'd0;
            rsp_acf_value  <= ONE_Q14;
            rsp_error      <= ERR_NONE;
            rsp_end_of_run <= (ml == 6'd0);
         end
         ST_EMIT: begin
            rsp_lag        <= lag_ff;
            rsp_acf_value  <= val_ff;
            rsp_error      <= ERR_NONE;
            rsp_end_of_run <= (lag_ff == ml);
         end
         default: begin
            rsp_lag        <= 6'd0;
            rsp_acf_value  <= '0;
            rsp_error      <= err_ff;
            rsp_end_of_run <= 1'b1;
         end
      endcase
   end
endmodule
